### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FBPA_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition implies an outcome in the next cycle, outside reset.
`define FBPA_ASSERT_NEXT(lbl, clk, rstn, cond, expct, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expct)) \
        else $error(msg);

`endif

### rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

    localparam int DEF_NUM_BLOCKS = 64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

endpackage

`default_nettype wire

### rtl/fbpa_link_mem.sv
`default_nettype none

module fbpa_link_mem #(
    parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS,
    parameter int IDX_W      = $clog2(fbpa_pkg::DEF_NUM_BLOCKS),
    parameter int LNK_W      = $clog2(fbpa_pkg::DEF_NUM_BLOCKS + 2)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [LNK_W-1:0] i_wdata,
    input  wire logic [LNK_W-1:0] i_raddr,
    output logic      [LNK_W-1:0] o_rdata
);
    import fbpa_pkg::*;

    logic [LNK_W-1:0]      r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [LNK_W-1:0]      r_mem_q;
    logic [LNK_W-1:0]      r_byp_data;
    logic [LNK_W-1:0]      r_raddr_q;
    logic                  r_byp;
    logic                  r_vld_q;
    logic [IDX_W-1:0]      rd_idx;

    assign rd_idx = i_raddr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_mem_q    <= r_mem[rd_idx];
        r_byp_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_byp     <= 1'b0;
            r_vld_q   <= 1'b0;
            r_raddr_q <= LNK_W'(1);
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_byp     <= i_we && (i_waddr == rd_idx);
            r_vld_q   <= r_vld[rd_idx];
            r_raddr_q <= i_raddr;
        end
    end

    // unwritten entries hold their reset link: the next block in order
    assign o_rdata = r_byp   ? r_byp_data :
                     r_vld_q ? r_mem_q    :
                               r_raddr_q + LNK_W'(1);

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator_unit.sv
// Channel   Valid     Stall     Payload
// request   i_valid   o_stall   i_kind, i_margin, i_block_index
// result    o_valid   i_stall   o_status, o_granted_block, o_free_count, o_min_free
//
// One request per cycle while the result is not stalled; its result appears in the cycle after the request beat.
// The rate is set by the free-list head, its link and the link after it, which are
// held in registers and refilled each cycle by one read of the link memory.
// Reset restores the full free list at once: valid bits mark links written since reset.
// A result stalled downstream holds the result register and stalls the request side.
`default_nettype none

module fixed_block_pool_allocator_unit #(
    parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS,
    localparam int IDX_W     = $clog2(NUM_BLOCKS),
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 2)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_kind,
    input  wire logic [CNT_W-1:0] i_margin,
    input  wire logic [IDX_W-1:0] i_block_index,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [1:0]       o_status,
    output logic      [IDX_W-1:0] o_granted_block,
    output logic      [CNT_W-1:0] o_free_count,
    output logic      [CNT_W-1:0] o_min_free
);
    import fbpa_pkg::*;

    `include "assert_macros.svh"

    localparam logic [CNT_W-1:0] L_NULL  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] L_ALLOC = CNT_W'(NUM_BLOCKS + 1);

    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_hnext, n_hnext;
    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_low, n_low;
    logic             r_o_vld;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_gblk, n_gblk;
    logic [CNT_W-1:0] r_o_free;
    logic [CNT_W-1:0] r_o_low;

    logic             in_acc;
    logic [CNT_W-1:0] w_nn;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [CNT_W-1:0] remaining;
    logic             empties;
    logic             head_bad;
    logic             next_bad;
    logic             blk_bad;
    logic             w_get_ok;

    assign o_stall   = r_o_vld && i_stall;
    assign in_acc    = i_valid && !o_stall;
    assign remaining = r_free - CNT_W'(1);
    assign empties   = (remaining == '0);
    assign head_bad  = (r_head >= L_NULL);
    assign next_bad  = empties ? (r_hnext != L_NULL) : (r_hnext >= L_NULL);
    assign blk_bad   = (CNT_W'(i_block_index) >= L_NULL);
    assign w_get_ok  = in_acc && !i_kind && (n_status == ST_OK);

    always_comb begin
        n_head    = r_head;
        n_hnext   = r_hnext;
        n_free    = r_free;
        n_low     = r_low;
        n_status  = ST_OK;
        n_gblk    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_head[IDX_W-1:0];
        mem_wdata = L_ALLOC;
        if (in_acc) begin
            if (!i_kind) begin
                if (!(r_free > i_margin)) begin
                    n_status = ST_REFUSED;
                end else if (head_bad || next_bad) begin
                    n_status = ST_INVALID;
                end else begin
                    mem_we  = 1'b1;
                    n_head  = r_hnext;
                    n_hnext = (r_hnext == r_head) ? L_ALLOC : w_nn;
                    n_free  = remaining;
                    n_low   = empties ? '0 : ((r_low > remaining) ? remaining : r_low);
                    n_gblk  = r_head[IDX_W-1:0];
                end
            end else begin
                if (r_free >= L_NULL) begin
                    n_status = ST_FULL;
                end else if (blk_bad) begin
                    n_status = ST_INVALID;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = i_block_index;
                    mem_wdata = r_head;
                    n_head    = CNT_W'(i_block_index);
                    n_hnext   = r_head;
                    n_free    = r_free + CNT_W'(1);
                end
            end
        end
    end

    fbpa_link_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W),
        .LNK_W      (CNT_W)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_hnext),
        .o_rdata (w_nn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_hnext <= CNT_W'(1);
            r_free  <= L_NULL;
            r_low   <= L_NULL;
            r_o_vld <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_hnext <= n_hnext;
            r_free  <= n_free;
            r_low   <= n_low;
            if (in_acc) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_gblk   <= n_gblk;
            r_o_free <= n_free;
            r_o_low  <= n_low;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_status        = r_status;
    assign o_granted_block = r_gblk;
    assign o_free_count    = r_o_free;
    assign o_min_free      = r_o_low;

    `FBPA_ASSERT_RST(a_free_bound, i_clk, i_rst_n, r_free <= L_NULL, "free count above pool size")
    `FBPA_ASSERT_RST(a_low_bound, i_clk, i_rst_n, r_low <= r_free, "low water above free count")
    `FBPA_ASSERT_NEXT(a_get_count, i_clk, i_rst_n, w_get_ok, r_free == ($past(r_free) - CNT_W'(1)), "granted get did not lower free count")
    `FBPA_ASSERT_NEXT(a_result_vld, i_clk, i_rst_n, in_acc, o_valid, "accepted beat gave no result")

endmodule

`default_nettype wire
